// ===== hdl/rhsv_pkg.sv =====
// shared types and constants for the rgb to hsv converter
package rhsv_pkg;

  // hue integer part covers 0..359 degrees
  localparam int HUE_INT_BITS   = 9;
  localparam int HUE_SECTOR_DEG = 60;
  localparam int HUE_CIRCLE_DEG = 360;
  // 60 fits in 6 bits, so the hue quotient needs 6 + fraction bits
  localparam int HUE_UNIT_BITS  = 6;

  typedef enum logic [1:0] {
    SECT_RED,
    SECT_GREEN,
    SECT_BLUE
  } hue_sector_t;

  typedef struct packed {
    hue_sector_t sector;
    logic        neg;
    logic        grey;
  } hue_ctrl_t;

endpackage

// ===== hdl/rhsv_pix_if.sv =====
// pixel input channel: valid/ready with red, green and blue components
interface rhsv_pix_if #(
  parameter int COMPONENT_BITS = 8
);
  logic                      valid;
  logic                      ready;
  logic [COMPONENT_BITS-1:0] red;
  logic [COMPONENT_BITS-1:0] green;
  logic [COMPONENT_BITS-1:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink   (input valid, red, green, blue, output ready);
endinterface

// ===== hdl/rhsv_hsv_if.sv =====
// result channel: valid/ready with hue, saturation and value
interface rhsv_hsv_if
  import rhsv_pkg::*;
#(
  parameter int COMPONENT_BITS    = 8,
  parameter int HUE_FRACTION_BITS = 4
);
  logic                                      valid;
  logic                                      ready;
  logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0] hue;
  logic [COMPONENT_BITS-1:0]                 saturation;
  logic [COMPONENT_BITS-1:0]                 value;

  modport source (output valid, hue, saturation, value, input ready);
  modport sink   (input valid, hue, saturation, value, output ready);
endinterface

// ===== hdl/rhsv_front.sv =====
// first stage: max, min, sector choice, delta and hue difference magnitude
module rhsv_front
  import rhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [COMPONENT_BITS-1:0] in_red,
  input  logic [COMPONENT_BITS-1:0] in_green,
  input  logic [COMPONENT_BITS-1:0] in_blue,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [COMPONENT_BITS-1:0] out_value,
  output logic [COMPONENT_BITS-1:0] out_delta,
  output logic [COMPONENT_BITS-1:0] out_adiff,
  output hue_ctrl_t                 out_ctrl
);

  logic                      valid_r;
  logic [COMPONENT_BITS-1:0] value_r, value_nxt;
  logic [COMPONENT_BITS-1:0] delta_r, delta_nxt;
  logic [COMPONENT_BITS-1:0] adiff_r, adiff_nxt;
  hue_ctrl_t                 ctrl_r, ctrl_nxt;
  logic [COMPONENT_BITS-1:0] min_c, dx, dy;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    min_c = in_red;
    if (in_green < min_c) min_c = in_green;
    if (in_blue < min_c) min_c = in_blue;

    // priority red, then green, then blue on ties
    if (in_red >= in_green && in_red >= in_blue) begin
      ctrl_nxt.sector = SECT_RED;
      value_nxt       = in_red;
      dx              = in_green;
      dy              = in_blue;
    end else if (in_green >= in_blue) begin
      ctrl_nxt.sector = SECT_GREEN;
      value_nxt       = in_green;
      dx              = in_blue;
      dy              = in_red;
    end else begin
      ctrl_nxt.sector = SECT_BLUE;
      value_nxt       = in_blue;
      dx              = in_red;
      dy              = in_green;
    end

    delta_nxt     = value_nxt - min_c;
    ctrl_nxt.grey = (value_nxt == min_c);
    ctrl_nxt.neg  = (dx < dy);
    adiff_nxt     = ctrl_nxt.neg ? (dy - dx) : (dx - dy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      value_r <= value_nxt;
      delta_r <= delta_nxt;
      adiff_r <= adiff_nxt;
      ctrl_r  <= ctrl_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_value = value_r;
  assign out_delta = delta_r;
  assign out_adiff = adiff_r;
  assign out_ctrl  = ctrl_r;

endmodule

// ===== hdl/rhsv_div_stage.sv =====
// one restoring division step for both the saturation and hue dividers
module rhsv_div_stage
  import rhsv_pkg::*;
#(
  parameter int COMPONENT_BITS = 8,
  parameter int QUOT_BITS      = 10,
  parameter int SHIFT          = 0
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [COMPONENT_BITS+QUOT_BITS-1:0] in_rem_s,
  input  logic [COMPONENT_BITS+QUOT_BITS-1:0] in_rem_h,
  input  logic [QUOT_BITS-1:0]                in_q_s,
  input  logic [QUOT_BITS-1:0]                in_q_h,
  input  logic [COMPONENT_BITS-1:0]           in_value,
  input  logic [COMPONENT_BITS-1:0]           in_delta,
  input  hue_ctrl_t                           in_ctrl,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [COMPONENT_BITS+QUOT_BITS-1:0] out_rem_s,
  output logic [COMPONENT_BITS+QUOT_BITS-1:0] out_rem_h,
  output logic [QUOT_BITS-1:0]                out_q_s,
  output logic [QUOT_BITS-1:0]                out_q_h,
  output logic [COMPONENT_BITS-1:0]           out_value,
  output logic [COMPONENT_BITS-1:0]           out_delta,
  output hue_ctrl_t                           out_ctrl
);

  localparam int RW = COMPONENT_BITS + QUOT_BITS;

  logic                      valid_r;
  logic [RW-1:0]             rem_s_r, rem_s_nxt, rem_h_r, rem_h_nxt;
  logic [QUOT_BITS-1:0]      q_s_r, q_s_nxt, q_h_r, q_h_nxt;
  logic [COMPONENT_BITS-1:0] value_r, delta_r;
  hue_ctrl_t                 ctrl_r;
  logic [RW:0]               trial_s, trial_h;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    trial_s = {1'b0, in_rem_s} - ({1'b0, RW'(in_value)} << SHIFT);
    trial_h = {1'b0, in_rem_h} - ({1'b0, RW'(in_delta)} << SHIFT);
    // a clear borrow bit means the shifted divisor fits
    rem_s_nxt      = trial_s[RW] ? in_rem_s : trial_s[RW-1:0];
    rem_h_nxt      = trial_h[RW] ? in_rem_h : trial_h[RW-1:0];
    q_s_nxt        = in_q_s;
    q_h_nxt        = in_q_h;
    q_s_nxt[SHIFT] = !trial_s[RW];
    q_h_nxt[SHIFT] = !trial_h[RW];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      rem_s_r <= rem_s_nxt;
      rem_h_r <= rem_h_nxt;
      q_s_r   <= q_s_nxt;
      q_h_r   <= q_h_nxt;
      value_r <= in_value;
      delta_r <= in_delta;
      ctrl_r  <= in_ctrl;
    end
  end

  assign out_valid = valid_r;
  assign out_rem_s = rem_s_r;
  assign out_rem_h = rem_h_r;
  assign out_q_s   = q_s_r;
  assign out_q_h   = q_h_r;
  assign out_value = value_r;
  assign out_delta = delta_r;
  assign out_ctrl  = ctrl_r;

endmodule

// ===== hdl/rhsv_back.sv =====
// last stage: sector offset, floor correction, wrap and output register
module rhsv_back
  import rhsv_pkg::*;
#(
  parameter int COMPONENT_BITS    = 8,
  parameter int HUE_FRACTION_BITS = 4,
  parameter int QUOT_BITS         = 10
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      in_valid,
  output logic                                      in_ready,
  input  logic [QUOT_BITS-1:0]                      in_q_s,
  input  logic [QUOT_BITS-1:0]                      in_q_h,
  input  logic [COMPONENT_BITS+QUOT_BITS-1:0]       in_rem_h,
  input  logic [COMPONENT_BITS-1:0]                 in_value,
  input  hue_ctrl_t                                 in_ctrl,
  output logic                                      out_valid,
  input  logic                                      out_ready,
  output logic [HUE_INT_BITS+HUE_FRACTION_BITS-1:0] out_hue,
  output logic [COMPONENT_BITS-1:0]                 out_saturation,
  output logic [COMPONENT_BITS-1:0]                 out_value
);

  localparam int HW = HUE_INT_BITS + HUE_FRACTION_BITS;
  localparam logic [HW-1:0] UNIT = HW'(HUE_SECTOR_DEG << HUE_FRACTION_BITS);
  localparam logic [HW-1:0] FULL = HW'(HUE_CIRCLE_DEG << HUE_FRACTION_BITS);

  logic                      valid_r;
  logic [HW-1:0]             hue_r, hue_nxt;
  logic [COMPONENT_BITS-1:0] sat_r, sat_nxt, value_r;
  logic [HW-1:0]             q_c, q_up, base_c;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    q_c  = HW'(in_q_h);
    // floor of a negative quotient rounds away from zero on a remainder
    q_up = q_c + HW'(in_rem_h != '0);
    case (in_ctrl.sector)
      SECT_RED:   base_c = in_ctrl.neg ? FULL : '0;
      SECT_GREEN: base_c = UNIT << 1;
      SECT_BLUE:  base_c = UNIT << 2;
      default:    base_c = '0;
    endcase
    hue_nxt = in_ctrl.neg ? (base_c - q_up) : (base_c + q_c);
    sat_nxt = in_q_s[COMPONENT_BITS-1:0];
    if (in_ctrl.grey) begin
      hue_nxt = '0;
      sat_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hue_r   <= hue_nxt;
      sat_r   <= sat_nxt;
      value_r <= in_value;
    end
  end

  assign out_valid      = valid_r;
  assign out_hue        = hue_r;
  assign out_saturation = sat_r;
  assign out_value      = value_r;

endmodule

// ===== hdl/rgb_to_hsv_converter_top.sv =====
// rgb to hsv converter: front stage, pipelined dividers and output stage
// throughput: one pixel per cycle while the output is not stalled; each divider stage resolves one quotient bit
// every stage has its own valid bit, so bubbles collapse under output stall
// reset: synchronous active-low rst_n clears all valid bits, payload not reset
module rgb_to_hsv_converter_top
  import rhsv_pkg::*;
#(
  parameter int COMPONENT_BITS    = 8,
  parameter int HUE_FRACTION_BITS = 4
) (
  input  logic          clk,
  input  logic          rst_n,
  rhsv_pix_if.sink      in_pix,
  rhsv_hsv_if.source    out_hsv
);

  localparam int HQW  = HUE_UNIT_BITS + HUE_FRACTION_BITS;
  localparam int QW   = (COMPONENT_BITS > HQW) ? COMPONENT_BITS : HQW;
  localparam int RW   = COMPONENT_BITS + QW;
  localparam int UNIT = HUE_SECTOR_DEG << HUE_FRACTION_BITS;

  logic                      valid_p [QW+1];
  logic                      ready_p [QW+1];
  logic [RW-1:0]             rem_s_p [QW+1];
  logic [RW-1:0]             rem_h_p [QW+1];
  logic [QW-1:0]             q_s_p   [QW+1];
  logic [QW-1:0]             q_h_p   [QW+1];
  logic [COMPONENT_BITS-1:0] value_p [QW+1];
  logic [COMPONENT_BITS-1:0] delta_p [QW+1];
  hue_ctrl_t                 ctrl_p  [QW+1];
  logic [COMPONENT_BITS-1:0] adiff_c;

  rhsv_front #(
    .COMPONENT_BITS (COMPONENT_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_pix.valid),
    .in_ready  (in_pix.ready),
    .in_red    (in_pix.red),
    .in_green  (in_pix.green),
    .in_blue   (in_pix.blue),
    .out_valid (valid_p[0]),
    .out_ready (ready_p[0]),
    .out_value (value_p[0]),
    .out_delta (delta_p[0]),
    .out_adiff (adiff_c),
    .out_ctrl  (ctrl_p[0])
  );

  // dividends: full scale times delta, and hue unit times difference
  assign rem_s_p[0] = (RW'(delta_p[0]) << COMPONENT_BITS) - RW'(delta_p[0]);
  assign rem_h_p[0] = RW'(adiff_c) * RW'(UNIT);
  assign q_s_p[0]   = '0;
  assign q_h_p[0]   = '0;

  for (genvar k = 0; k < QW; k++) begin : g_div
    rhsv_div_stage #(
      .COMPONENT_BITS (COMPONENT_BITS),
      .QUOT_BITS      (QW),
      .SHIFT          (QW - 1 - k)
    ) u_stage (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (valid_p[k]),
      .in_ready  (ready_p[k]),
      .in_rem_s  (rem_s_p[k]),
      .in_rem_h  (rem_h_p[k]),
      .in_q_s    (q_s_p[k]),
      .in_q_h    (q_h_p[k]),
      .in_value  (value_p[k]),
      .in_delta  (delta_p[k]),
      .in_ctrl   (ctrl_p[k]),
      .out_valid (valid_p[k+1]),
      .out_ready (ready_p[k+1]),
      .out_rem_s (rem_s_p[k+1]),
      .out_rem_h (rem_h_p[k+1]),
      .out_q_s   (q_s_p[k+1]),
      .out_q_h   (q_h_p[k+1]),
      .out_value (value_p[k+1]),
      .out_delta (delta_p[k+1]),
      .out_ctrl  (ctrl_p[k+1])
    );
  end

  rhsv_back #(
    .COMPONENT_BITS    (COMPONENT_BITS),
    .HUE_FRACTION_BITS (HUE_FRACTION_BITS),
    .QUOT_BITS         (QW)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (valid_p[QW]),
    .in_ready       (ready_p[QW]),
    .in_q_s         (q_s_p[QW]),
    .in_q_h         (q_h_p[QW]),
    .in_rem_h       (rem_h_p[QW]),
    .in_value       (value_p[QW]),
    .in_ctrl        (ctrl_p[QW]),
    .out_valid      (out_hsv.valid),
    .out_ready      (out_hsv.ready),
    .out_hue        (out_hsv.hue),
    .out_saturation (out_hsv.saturation),
    .out_value      (out_hsv.value)
  );

endmodule

// ===== test/tb_rgb_to_hsv_converter_top.sv =====
// self-checking testbench for the rgb to hsv converter with random stalls on both channels
`timescale 1ns / 1ps

module tb_rgb_to_hsv_converter_top
  import rhsv_pkg::*;
();

  localparam int COMP_BITS  = 8;
  localparam int HUE_FRAC   = 4;
  localparam int HUE_BITS   = HUE_INT_BITS + HUE_FRAC;
  localparam int COMP_FULL  = (1 << COMP_BITS) - 1;
  localparam int HUE_UNIT   = HUE_SECTOR_DEG << HUE_FRAC;
  localparam int HUE_CIRCLE = HUE_CIRCLE_DEG << HUE_FRAC;
  localparam int LATENCY    = 12;
  localparam int IDLE_PCT   = 7;
  localparam int RAND_ITEMS = 1950;
  localparam int QUIET_FROM = 400;
  localparam int QUIET_TO   = 1000;
  localparam int HOLD_START = 1200;
  localparam int HOLD_LEN   = 300;

  typedef struct packed {
    logic [COMP_BITS-1:0] red;
    logic [COMP_BITS-1:0] green;
    logic [COMP_BITS-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [HUE_BITS-1:0]  hue;
    logic [COMP_BITS-1:0] saturation;
    logic [COMP_BITS-1:0] value;
  } hsv_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  int unsigned cyc = 0;
  int unsigned pixels_total = 0;
  int unsigned pixels_accepted = 0;
  int unsigned error_count = 0;
  logic        hold_off = 1'b0;
  int unsigned hold_cnt = 0;

  pixel_t pixel_queue[$];
  hsv_t   hsv_expected[$];

  rhsv_pix_if #(.COMPONENT_BITS(COMP_BITS)) pix_ch ();
  rhsv_hsv_if #(.COMPONENT_BITS(COMP_BITS), .HUE_FRACTION_BITS(HUE_FRAC)) hsv_ch ();

  rgb_to_hsv_converter_top #(
    .COMPONENT_BITS    (COMP_BITS),
    .HUE_FRACTION_BITS (HUE_FRAC)
  ) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_pix  (pix_ch),
    .out_hsv (hsv_ch)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cyc <= cyc + 1;
  end

  // random idling is switched off inside the quiet window
  wire noisy = !(cyc >= QUIET_FROM && cyc < QUIET_TO);

  function automatic hsv_t hsv_predict(input logic [COMP_BITS-1:0] r,
                                       input logic [COMP_BITS-1:0] g,
                                       input logic [COMP_BITS-1:0] b);
    int          mx;
    int          mn;
    int          dlt;
    int          diff;
    int          num;
    int          quo;
    int          h;
    hue_sector_t sect;
    hsv_t        res;
    mx = int'(r);
    mn = int'(r);
    if (int'(g) > mx) mx = int'(g);
    if (int'(b) > mx) mx = int'(b);
    if (int'(g) < mn) mn = int'(g);
    if (int'(b) < mn) mn = int'(b);
    dlt = mx - mn;
    res = '0;
    res.value = mx[COMP_BITS-1:0];
    if (dlt > 0) begin
      res.saturation = COMP_BITS'((COMP_FULL * dlt) / mx);
      // priority red, then green, then blue on ties
      if (int'(r) == mx) begin
        sect = SECT_RED;
        diff = int'(g) - int'(b);
      end else if (int'(g) == mx) begin
        sect = SECT_GREEN;
        diff = int'(b) - int'(r);
      end else begin
        sect = SECT_BLUE;
        diff = int'(r) - int'(g);
      end
      num = HUE_UNIT * diff;
      // floor toward minus infinity
      if (num >= 0) quo = num / dlt;
      else quo = -((-num + dlt - 1) / dlt);
      case (sect)
        SECT_RED: begin
          h = quo;
          if (h < 0) h += HUE_CIRCLE;
        end
        SECT_GREEN: h = 2 * HUE_UNIT + quo;
        default:    h = 4 * HUE_UNIT + quo;
      endcase
      res.hue = h[HUE_BITS-1:0];
    end
    return res;
  endfunction

  function automatic logic [COMP_BITS-1:0] extreme_level();
    case ($urandom_range(4))
      0:       return '0;
      1:       return COMP_BITS'(1);
      2:       return COMP_BITS'(COMP_FULL - 1);
      3:       return COMP_BITS'(COMP_FULL);
      default: return COMP_BITS'($urandom_range(COMP_FULL));
    endcase
  endfunction

  // input side: one transfer per valid/ready edge
  always @(posedge clk) begin : pixel_driver
    pixel_t nxt;
    logic   held;
    if (!rst_n) begin
      pix_ch.valid <= 1'b0;
      pix_ch.red   <= '0;
      pix_ch.green <= '0;
      pix_ch.blue  <= '0;
    end else begin
      held = pix_ch.valid;
      if (pix_ch.valid && pix_ch.ready) begin
        hsv_expected.push_back(hsv_predict(pix_ch.red, pix_ch.green, pix_ch.blue));
        pixels_accepted++;
        held = 1'b0;
      end
      if (!held) begin
        if (pixel_queue.size() != 0 && !(noisy && $urandom_range(99) < IDLE_PCT)) begin
          nxt = pixel_queue.pop_front();
          pix_ch.valid <= 1'b1;
          pix_ch.red   <= nxt.red;
          pix_ch.green <= nxt.green;
          pix_ch.blue  <= nxt.blue;
        end else begin
          pix_ch.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the pipeline fills and backs up
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_cnt <= 0;
    end else if (cyc == HOLD_START) begin
      hold_off <= 1'b1;
      hold_cnt <= HOLD_LEN;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
      if (hold_cnt == 1) hold_off <= 1'b0;
    end
  end

  // output side: check every result transfer against the oldest prediction
  always @(posedge clk) begin : hsv_monitor
    hsv_t want;
    if (!rst_n) begin
      hsv_ch.ready <= 1'b0;
    end else begin
      if (hsv_ch.valid && hsv_ch.ready) begin
        if (hsv_expected.size() == 0) begin
          $display("%0t: result with nothing expected: hue %0d sat %0d val %0d", $time,
                   hsv_ch.hue, hsv_ch.saturation, hsv_ch.value);
          error_count++;
        end else begin
          want = hsv_expected.pop_front();
          if (hsv_ch.hue !== want.hue) begin
            $display("%0t: hue mismatch: expected %0d actual %0d", $time, want.hue,
                     hsv_ch.hue);
            error_count++;
          end
          if (hsv_ch.saturation !== want.saturation) begin
            $display("%0t: saturation mismatch: expected %0d actual %0d", $time,
                     want.saturation, hsv_ch.saturation);
            error_count++;
          end
          if (hsv_ch.value !== want.value) begin
            $display("%0t: value mismatch: expected %0d actual %0d", $time, want.value,
                     hsv_ch.value);
            error_count++;
          end
        end
      end
      hsv_ch.ready <= !hold_off && !(noisy && $urandom_range(99) < IDLE_PCT);
    end
  end

  initial begin
    #1ms;
    $display("*** FAILED ***");
    $finish;
  end

  initial begin : stimulus
    int                   sel;
    logic [COMP_BITS-1:0] lv_a;
    logic [COMP_BITS-1:0] lv_b;
    pixel_t               px;

    // directed: greys, primaries, secondaries with ties, red-sector wrap, extremes
    pixel_queue.push_back('{8'd0,   8'd0,   8'd0});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd128, 8'd128, 8'd128});
    pixel_queue.push_back('{8'd1,   8'd1,   8'd1});
    pixel_queue.push_back('{8'd255, 8'd0,   8'd0});
    pixel_queue.push_back('{8'd0,   8'd255, 8'd0});
    pixel_queue.push_back('{8'd0,   8'd0,   8'd255});
    pixel_queue.push_back('{8'd255, 8'd255, 8'd0});
    pixel_queue.push_back('{8'd0,   8'd255, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd0,   8'd255});
    pixel_queue.push_back('{8'd255, 8'd0,   8'd1});
    pixel_queue.push_back('{8'd255, 8'd0,   8'd254});
    pixel_queue.push_back('{8'd1,   8'd0,   8'd0});
    pixel_queue.push_back('{8'd0,   8'd1,   8'd0});
    pixel_queue.push_back('{8'd0,   8'd0,   8'd1});
    pixel_queue.push_back('{8'd1,   8'd0,   8'd1});
    pixel_queue.push_back('{8'd255, 8'd254, 8'd0});
    pixel_queue.push_back('{8'd254, 8'd255, 8'd255});
    pixel_queue.push_back('{8'd255, 8'd254, 8'd255});
    pixel_queue.push_back('{8'd128, 8'd0,   8'd255});
    pixel_queue.push_back('{8'd0,   8'd128, 8'd255});
    pixel_queue.push_back('{8'd170, 8'd85,  8'd0});

    for (int i = 0; i < RAND_ITEMS; i++) begin
      sel = $urandom_range(9);
      if (sel < 6) begin
        px.red   = COMP_BITS'($urandom_range(COMP_FULL));
        px.green = COMP_BITS'($urandom_range(COMP_FULL));
        px.blue  = COMP_BITS'($urandom_range(COMP_FULL));
      end else if (sel < 8) begin
        // two levels only, so ties between components come up often
        lv_a     = COMP_BITS'($urandom_range(COMP_FULL));
        lv_b     = COMP_BITS'($urandom_range(COMP_FULL));
        px.red   = $urandom_range(1) ? lv_a : lv_b;
        px.green = $urandom_range(1) ? lv_a : lv_b;
        px.blue  = $urandom_range(1) ? lv_a : lv_b;
      end else begin
        px.red   = extreme_level();
        px.green = extreme_level();
        px.blue  = extreme_level();
      end
      pixel_queue.push_back(px);
    end
    pixels_total = pixel_queue.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    while (pixels_accepted != pixels_total) @(posedge clk);
    while (hsv_expected.size() != 0) @(posedge clk);
    repeat (2 * LATENCY) @(posedge clk);

    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/rhsv_pkg.sv
hdl/rhsv_pix_if.sv
hdl/rhsv_hsv_if.sv
hdl/rhsv_front.sv
hdl/rhsv_div_stage.sv
hdl/rhsv_back.sv
hdl/rgb_to_hsv_converter_top.sv
test/tb_rgb_to_hsv_converter_top.sv
